@@ sv/cbm_pkg.sv @@
package cbm_pkg;

	localparam int unsigned SERIAL_LEN = 5;

	typedef enum logic [1:0] {
		FUNC_LOAD      = 2'd0,
		FUNC_WRITE     = 2'd1,
		FUNC_TRANSLATE = 2'd2,
		FUNC_SPARE     = 2'd3
	} func_t;

	localparam logic [3:0] MAPPER_SERIAL = 4'd1;
	localparam logic [3:0] MAPPER_PRG    = 4'd2;
	localparam logic [3:0] MAPPER_CHR    = 4'd3;
	localparam logic [3:0] MAPPER_PRG32  = 4'd7;

	localparam logic [1:0] CFG_MAPPER_NUMBER  = 2'd0;
	localparam logic [1:0] CFG_PRG_BANK_COUNT = 2'd1;
	localparam logic [1:0] CFG_CHR_BANK_COUNT = 2'd2;
	localparam logic [1:0] CFG_VERT_MIRROR    = 2'd3;

	localparam logic [1:0] MIRROR_SINGLE0    = 2'd0;
	localparam logic [1:0] MIRROR_SINGLE1    = 2'd1;
	localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;
	localparam logic [1:0] MIRROR_HORIZONTAL = 2'd3;

	localparam logic [2:0] SERIAL_COUNT_RESET = 3'(SERIAL_LEN);
	localparam logic [4:0] SERIAL_RESET_BITS  = 5'b01100;

	typedef struct packed {
		logic [3:0] mapper_number;
		logic [7:0] prg_bank_count;
		logic [7:0] chr_bank_count;
		logic       vertical_mirroring;
	} cfg_t;

	typedef struct packed {
		func_t       func;
		logic [15:0] cpu_addr;
		logic [7:0]  write_data;
		logic [13:0] video_addr;
	} item_t;

	typedef struct packed {
		logic [10:0] nametable_index;
		logic [1:0]  mirror_mode;
		logic [19:0] chr_offset;
		logic [21:0] prg_offset;
	} result_t;

	typedef struct packed {
		logic [7:0] prg_sel0;
		logic [7:0] prg_sel1;
		logic [7:0] chr_sel0;
		logic [7:0] chr_sel1;
		logic [1:0] mirroring;
		logic [4:0] serial_shift;
		logic [2:0] serial_count;
		logic [4:0] serial_control;
		logic [4:0] serial_chr_low;
		logic [4:0] serial_chr_high;
		logic [4:0] serial_prg;
	} bank_state_t;

	localparam bank_state_t BANK_STATE_RESET = '{
		prg_sel0:        8'd0,
		prg_sel1:        8'd0,
		chr_sel0:        8'd0,
		chr_sel1:        8'd0,
		mirroring:       2'd0,
		serial_shift:    5'd0,
		serial_count:    SERIAL_COUNT_RESET,
		serial_control:  5'd0,
		serial_chr_low:  5'd0,
		serial_chr_high: 5'd0,
		serial_prg:      5'd0
	};

endpackage

@@ sv/cbm_update.sv @@
module cbm_update import cbm_pkg::*; (
	input  cfg_t        cfg,
	input  bank_state_t state,
	input  item_t       item,
	output bank_state_t state_next,
	output result_t     result
);

	function automatic bank_state_t serial_banks(bank_state_t s, logic [7:0] prg_count);
		bank_state_t r;
		r = s;
		if (s.serial_control[4]) begin
			r.chr_sel0 = {3'b000, s.serial_chr_low};
			r.chr_sel1 = {3'b000, s.serial_chr_high};
		end else begin
			r.chr_sel0 = {3'b000, s.serial_chr_low[4:1], 1'b0};
			r.chr_sel1 = {3'b000, s.serial_chr_low[4:1], 1'b1};
		end
		case (s.serial_control[3:2])
			2'd2: begin
				r.prg_sel0 = 8'd0;
				r.prg_sel1 = {3'b000, s.serial_prg};
			end
			2'd3: begin
				r.prg_sel0 = {3'b000, s.serial_prg};
				r.prg_sel1 = prg_count - 8'd1;
			end
			default: begin
				r.prg_sel0 = {3'b000, s.serial_prg[4:1], 1'b0};
				r.prg_sel1 = {3'b000, s.serial_prg[4:1], 1'b1};
			end
		endcase
		return r;
	endfunction

	bank_state_t ns;
	bank_state_t ser;
	logic [4:0]  shift_new;
	logic [2:0]  count_new;
	logic [7:0]  chr_count;
	logic [7:0]  prg_pick;
	logic [7:0]  chr_pick;

	always_comb begin
		ser       = state;
		shift_new = {item.write_data[0], state.serial_shift[4:1]};
		count_new = state.serial_count - 3'd1;
		if (item.write_data[7]) begin
			ser.serial_count   = SERIAL_COUNT_RESET;
			ser.serial_shift   = 5'd0;
			ser.serial_control = state.serial_control | SERIAL_RESET_BITS;
			ser                = serial_banks(ser, cfg.prg_bank_count);
		end else if (count_new != 3'd0) begin
			ser.serial_shift = shift_new;
			ser.serial_count = count_new;
		end else begin
			ser.serial_count = SERIAL_COUNT_RESET;
			ser.serial_shift = 5'd0;
			case (item.cpu_addr[14:13])
				2'd0: begin
					ser.serial_control = shift_new;
					ser.mirroring      = shift_new[1:0];
				end
				2'd1:    ser.serial_chr_low  = shift_new;
				2'd2:    ser.serial_chr_high = shift_new;
				default: ser.serial_prg      = shift_new;
			endcase
			ser = serial_banks(ser, cfg.prg_bank_count);
		end
	end

	always_comb begin
		ns        = state;
		chr_count = (cfg.chr_bank_count == 8'd0) ? 8'd1 : cfg.chr_bank_count;
		case (item.func)
			FUNC_LOAD: begin
				ns.prg_sel0  = 8'd0;
				ns.prg_sel1  = cfg.prg_bank_count - 8'd1;
				ns.chr_sel0  = 8'd0;
				ns.chr_sel1  = {chr_count[6:0], 1'b0} - 8'd1;
				ns.mirroring = cfg.vertical_mirroring ? MIRROR_VERTICAL : MIRROR_HORIZONTAL;
			end
			FUNC_WRITE: begin
				if (item.cpu_addr[15]) begin
					unique case (cfg.mapper_number)
						MAPPER_PRG32: begin
							ns.mirroring = {1'b0, item.write_data[4]};
							ns.prg_sel0  = {4'd0, item.write_data[2:0], 1'b0};
							ns.prg_sel1  = {4'd0, item.write_data[2:0], 1'b1};
						end
						MAPPER_CHR: begin
							ns.chr_sel0 = {5'd0, item.write_data[1:0], 1'b0};
							ns.chr_sel1 = {5'd0, item.write_data[1:0], 1'b1};
						end
						MAPPER_PRG: ns.prg_sel0 = {3'b000, item.write_data[4:0]};
						MAPPER_SERIAL: ns = ser;
						default: ns = state;
					endcase
				end
			end
			default: ns = state;
		endcase
	end

	assign prg_pick = item.cpu_addr[14] ? ns.prg_sel1 : ns.prg_sel0;
	assign chr_pick = item.video_addr[12] ? ns.chr_sel1 : ns.chr_sel0;

	always_comb begin
		result.prg_offset  = {prg_pick, item.cpu_addr[13:0]};
		result.chr_offset  = item.video_addr[13] ? 20'd0 : {chr_pick, item.video_addr[11:0]};
		result.mirror_mode = ns.mirroring;
		case (ns.mirroring)
			MIRROR_SINGLE0:  result.nametable_index = {1'b0, item.video_addr[9:0]};
			MIRROR_SINGLE1:  result.nametable_index = {1'b1, item.video_addr[9:0]};
			MIRROR_VERTICAL: result.nametable_index = item.video_addr[10:0];
			default:         result.nametable_index = {item.video_addr[11], item.video_addr[9:0]};
		endcase
	end

	assign state_next = ns;

endmodule

@@ sv/cartridge_bank_mapper_top.sv @@
// A word accepted into the input register has its result word registered in the result register
// at the first edge that finds the result register free.
// One word per cycle while m_tready is high; an input register and the result register part the two sides.
// Reset (arst_n low, asynchronous) clears both valid flags, loads the register defaults and sets
// the bank state to zero with the serial count at five.
module cartridge_bank_mapper_top import cbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: func, cpu_addr, write_data, video_addr.
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: prg_offset, chr_offset, nametable_index, mirror_mode, zero fill.
	output logic [55:0] m_tdata
);

	cfg_t        cfg_q;
	bank_state_t state_q;
	bank_state_t state_next;
	item_t       item_s1;
	logic        valid_s1;
	result_t     result;
	result_t     result_q;
	logic        out_valid_q;
	logic        advance;
	item_t       item_in;

	assign item_in.func       = func_t'(s_tdata[1:0]);
	assign item_in.cpu_addr   = s_tdata[17:2];
	assign item_in.write_data = s_tdata[25:18];
	assign item_in.video_addr = s_tdata[39:26];

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	cbm_update u_update (
		.cfg        (cfg_q),
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mapper_number      <= 4'd0;
			cfg_q.prg_bank_count     <= 8'd2;
			cfg_q.chr_bank_count     <= 8'd1;
			cfg_q.vertical_mirroring <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAPPER_NUMBER:  cfg_q.mapper_number      <= cfg_data[3:0];
				CFG_PRG_BANK_COUNT: cfg_q.prg_bank_count     <= cfg_data;
				CFG_CHR_BANK_COUNT: cfg_q.chr_bank_count     <= cfg_data;
				CFG_VERT_MIRROR:    cfg_q.vertical_mirroring <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BANK_STATE_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, result_q.mirror_mode, result_q.nametable_index,
		result_q.chr_offset, result_q.prg_offset};

endmodule

@@ test/cartridge_bank_mapper_top_tb.sv @@
module cartridge_bank_mapper_top_tb;
	import cbm_pkg::*;

	localparam logic [3:0] MAPPER_NONE = 4'd0;
	localparam logic [3:0] MAPPER_LAST = 4'd15;
	localparam logic [1:0] SERIAL_REG_CONTROL = 2'd0;
	localparam logic [1:0] SERIAL_REG_CHR_LOW = 2'd1;
	localparam logic [1:0] SERIAL_REG_CHR_HIGH = 2'd2;
	localparam logic [1:0] SERIAL_REG_PRG = 2'd3;
	localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_LAST = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;

	cfg_t        cart;
	bank_state_t banks;
	result_t     due_results[$];
	int          bad_words;
	int          cycle_count;
	bit          feed_gaps;
	bit          drain_gaps;
	bit          hold_request;

	cartridge_bank_mapper_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic refresh_serial_banks();
		if (banks.serial_control[4]) begin
			banks.chr_sel0 = {3'b0, banks.serial_chr_low};
			banks.chr_sel1 = {3'b0, banks.serial_chr_high};
		end else begin
			banks.chr_sel0 = {3'b0, banks.serial_chr_low[4:1], 1'b0};
			banks.chr_sel1 = {3'b0, banks.serial_chr_low[4:1], 1'b1};
		end
		case (banks.serial_control[3:2])
			PRG_MODE_FIX_FIRST: begin
				banks.prg_sel0 = 8'd0;
				banks.prg_sel1 = {3'b0, banks.serial_prg};
			end
			PRG_MODE_FIX_LAST: begin
				banks.prg_sel0 = {3'b0, banks.serial_prg};
				banks.prg_sel1 = cart.prg_bank_count - 8'd1;
			end
			default: begin
				banks.prg_sel0 = {3'b0, banks.serial_prg[4:1], 1'b0};
				banks.prg_sel1 = {3'b0, banks.serial_prg[4:1], 1'b1};
			end
		endcase
	endtask

	task automatic shift_serial(input logic [15:0] cpu, input logic [7:0] data);
		if (data[7]) begin
			banks.serial_count = SERIAL_COUNT_RESET;
			banks.serial_shift = 5'd0;
			banks.serial_control = banks.serial_control | SERIAL_RESET_BITS;
			refresh_serial_banks();
			return;
		end
		banks.serial_shift = {data[0], banks.serial_shift[4:1]};
		banks.serial_count = banks.serial_count - 3'd1;
		if (banks.serial_count != 3'd0)
			return;
		banks.serial_count = SERIAL_COUNT_RESET;
		case (cpu[14:13])
			SERIAL_REG_CONTROL: begin
				banks.serial_control = banks.serial_shift;
				banks.mirroring = banks.serial_shift[1:0];
			end
			SERIAL_REG_CHR_LOW: banks.serial_chr_low = banks.serial_shift;
			SERIAL_REG_CHR_HIGH: banks.serial_chr_high = banks.serial_shift;
			default: banks.serial_prg = banks.serial_shift;
		endcase
		banks.serial_shift = 5'd0;
		refresh_serial_banks();
	endtask

	task automatic map_access(input func_t f, input logic [15:0] cpu, input logic [7:0] data,
			input logic [13:0] va, output result_t r);
		logic [7:0] chr_banks;
		case (f)
			FUNC_LOAD: begin
				chr_banks = (cart.chr_bank_count == 8'd0) ? 8'd1 : cart.chr_bank_count;
				banks.prg_sel0 = 8'd0;
				banks.prg_sel1 = cart.prg_bank_count - 8'd1;
				banks.chr_sel0 = 8'd0;
				banks.chr_sel1 = {chr_banks[6:0], 1'b0} - 8'd1;
				banks.mirroring = cart.vertical_mirroring ? MIRROR_VERTICAL : MIRROR_HORIZONTAL;
			end
			FUNC_WRITE: begin
				if (cpu[15]) begin
					case (cart.mapper_number)
						MAPPER_PRG32: begin
							banks.mirroring = data[4] ? MIRROR_SINGLE1 : MIRROR_SINGLE0;
							banks.prg_sel0 = {4'b0, data[2:0], 1'b0};
							banks.prg_sel1 = {4'b0, data[2:0], 1'b1};
						end
						MAPPER_CHR: begin
							banks.chr_sel0 = {5'b0, data[1:0], 1'b0};
							banks.chr_sel1 = {5'b0, data[1:0], 1'b1};
						end
						MAPPER_PRG: banks.prg_sel0 = {3'b0, data[4:0]};
						MAPPER_SERIAL: shift_serial(cpu, data);
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		r.prg_offset = {cpu[14] ? banks.prg_sel1 : banks.prg_sel0, cpu[13:0]};
		r.chr_offset = va[13] ? 20'd0 : {va[12] ? banks.chr_sel1 : banks.chr_sel0, va[11:0]};
		case (banks.mirroring)
			MIRROR_SINGLE0: r.nametable_index = {1'b0, va[9:0]};
			MIRROR_SINGLE1: r.nametable_index = {1'b1, va[9:0]};
			MIRROR_VERTICAL: r.nametable_index = va[10:0];
			default: r.nametable_index = {va[11], va[9:0]};
		endcase
		r.mirror_mode = banks.mirroring;
	endtask

	task automatic offer_access(input func_t f, input logic [15:0] cpu, input logic [7:0] data,
			input logic [13:0] va);
		result_t r;
		if (feed_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {va, data, cpu, f};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		map_access(f, cpu, data, va, r);
		due_results.push_back(r);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [7:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic setup_cart(input logic [3:0] kind, input logic [7:0] prg, input logic [7:0] chr,
			input logic vm);
		wait_drained();
		put_reg(CFG_MAPPER_NUMBER, {4'b0, kind});
		put_reg(CFG_PRG_BANK_COUNT, prg);
		put_reg(CFG_CHR_BANK_COUNT, chr);
		put_reg(CFG_VERT_MIRROR, {7'b0, vm});
		@(posedge clk);
		cfg_we <= 1'b0;
		cart.mapper_number = kind;
		cart.prg_bank_count = prg;
		cart.chr_bank_count = chr;
		cart.vertical_mirroring = vm;
	endtask

	function automatic logic [15:0] rand_cpu();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		return {1'b1, 15'($urandom)};
	endfunction

	function automatic logic [7:0] rand_count(input int lowest);
		case ($urandom_range(0, 5))
			0: return 8'(lowest);
			1: return 8'd255;
			default: return 8'($urandom_range(lowest, 255));
		endcase
	endfunction

	// Five single-bit writes to one serial register, least significant bit first.
	task automatic serial_load(input logic [1:0] reg_sel, input logic [4:0] value);
		for (int i = 0; i < SERIAL_LEN; i++)
			offer_access(FUNC_WRITE, {1'b1, reg_sel, 13'($urandom)},
				{1'b0, 6'($urandom), value[i]}, 14'($urandom));
	endtask

	task automatic run_random_accesses(input int count);
		int n;
		int pick;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				offer_access(FUNC_LOAD, rand_cpu(), 8'($urandom), 14'($urandom));
				n++;
			end else if (pick < 15) begin
				offer_access(FUNC_SPARE, rand_cpu(), 8'($urandom), 14'($urandom));
				n++;
			end else if (pick < 45) begin
				offer_access(FUNC_TRANSLATE, rand_cpu(), 8'($urandom), 14'($urandom));
				n++;
			end else if (cart.mapper_number == MAPPER_SERIAL && pick < 90) begin
				serial_load(2'($urandom), 5'($urandom));
				n += SERIAL_LEN;
			end else begin
				offer_access(FUNC_WRITE, rand_cpu(), 8'($urandom), 14'($urandom));
				n++;
			end
		end
	endtask

	task automatic random_phase(input logic [3:0] kind);
		setup_cart(kind, rand_count(1), rand_count(0), 1'($urandom));
		run_random_accesses(80);
	endtask

	task automatic test_reset_defaults();
		offer_access(FUNC_TRANSLATE, 16'h8000, 8'h00, 14'h0000);
		offer_access(FUNC_SPARE, 16'h7FFF, 8'h00, 14'h3FFF);
		offer_access(FUNC_WRITE, 16'hFFFF, 8'hFF, 14'h1FFF);
	endtask

	task automatic test_prg32_kind();
		setup_cart(MAPPER_PRG32, 8'd255, 8'd0, 1'b1);
		offer_access(FUNC_LOAD, 16'hC000, 8'h00, 14'h2C00);
		offer_access(FUNC_WRITE, 16'hFFFF, 8'h17, 14'h2400);
		offer_access(FUNC_WRITE, 16'h7FFF, 8'h08, 14'h0FFF);
	endtask

	task automatic test_chr_kind();
		setup_cart(MAPPER_CHR, 8'd1, 8'd255, 1'b0);
		offer_access(FUNC_LOAD, 16'hFFFF, 8'h00, 14'h1FFF);
		offer_access(FUNC_WRITE, 16'hC000, 8'hFF, 14'h1000);
	endtask

	task automatic test_prg_kind();
		setup_cart(MAPPER_PRG, 8'd8, 8'd128, 1'b0);
		offer_access(FUNC_LOAD, 16'hC000, 8'h00, 14'h0800);
		offer_access(FUNC_WRITE, 16'h8000, 8'h1F, 14'h3C00);
	endtask

	task automatic test_serial_kind();
		setup_cart(MAPPER_SERIAL, 8'd16, 8'd2, 1'b1);
		offer_access(FUNC_WRITE, 16'h8000, 8'h80, 14'h1000);
		serial_load(SERIAL_REG_CONTROL, 5'b10011);
		serial_load(SERIAL_REG_PRG, 5'b11101);
		offer_access(FUNC_WRITE, 16'hA000, 8'h01, 14'h0000);
		offer_access(FUNC_WRITE, 16'hE000, 8'hFF, 14'h3FFF);
	endtask

	task automatic test_random_kinds();
		random_phase(MAPPER_SERIAL);
		random_phase(MAPPER_PRG);
		random_phase(MAPPER_CHR);
		random_phase(MAPPER_PRG32);
		random_phase(MAPPER_LAST);
		random_phase(MAPPER_SERIAL);
		random_phase(MAPPER_NONE);
	endtask

	task automatic test_backpressure();
		setup_cart(MAPPER_SERIAL, rand_count(1), rand_count(0), 1'($urandom));
		feed_gaps = 1'b0;
		hold_request = 1'b1;
		run_random_accesses(40);
		feed_gaps = 1'b1;
	endtask

	task automatic test_pause_resume();
		run_random_accesses(15);
		wait_drained();
		run_random_accesses(15);
	endtask

	task automatic test_steady_stream();
		feed_gaps = 1'b0;
		drain_gaps = 1'b0;
		run_random_accesses(60);
	endtask

	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (drain_gaps && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				$error("result word with nothing expected: %0h", m_tdata);
				bad_words++;
			end else begin
				want = due_results.pop_front();
				if (m_tdata[21:0] !== want.prg_offset) begin
					$error("prg_offset: expected %0h, got %0h", want.prg_offset, m_tdata[21:0]);
					bad_words++;
				end
				if (m_tdata[41:22] !== want.chr_offset) begin
					$error("chr_offset: expected %0h, got %0h", want.chr_offset, m_tdata[41:22]);
					bad_words++;
				end
				if (m_tdata[52:42] !== want.nametable_index) begin
					$error("nametable_index: expected %0h, got %0h", want.nametable_index,
						m_tdata[52:42]);
					bad_words++;
				end
				if (m_tdata[54:53] !== want.mirror_mode) begin
					$error("mirror_mode: expected %0h, got %0h", want.mirror_mode, m_tdata[54:53]);
					bad_words++;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAPPER_NUMBER;
		cfg_data = 8'd0;
		s_tvalid = 1'b0;
		s_tdata = 40'd0;
		bad_words = 0;
		cycle_count = 0;
		hold_request = 1'b0;
		feed_gaps = 1'b1;
		drain_gaps = 1'b1;
		cart.mapper_number = MAPPER_NONE;
		cart.prg_bank_count = 8'd2;
		cart.chr_bank_count = 8'd1;
		cart.vertical_mirroring = 1'b0;
		banks = '0;
		banks.serial_count = SERIAL_COUNT_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_prg32_kind();
		test_chr_kind();
		test_prg_kind();
		test_serial_kind();
		test_random_kinds();
		test_backpressure();
		test_pause_resume();
		test_steady_stream();
		wait_drained();
		repeat (6) @(posedge clk);
		if (bad_words == 0 && due_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
